// ===== rtl/core/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the Mandelbrot escape-time engine.
// ----------------------------------------------------------------------------
package mbe_pkg;

  // Payload widths
  localparam int unsigned IndexWidth = 10;
  localparam int unsigned FixWidth   = 32;
  localparam int unsigned StepWidth  = 31;
  localparam int unsigned IterWidth  = 16;

  // Configuration port
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 32;

  localparam logic [CfgIdxWidth-1:0] CfgOriginReal = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgOriginImag = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgStepReal   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgStepImag   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgIterLimit  = 3'd4;

  // Register reset values (Q4.28)
  localparam logic signed [FixWidth-1:0] OriginRealRst = -32'sd402653184;  // -1.5
  localparam logic signed [FixWidth-1:0] OriginImagRst = -32'sd268435456;  // -1.0
  localparam logic [StepWidth-1:0]       StepRealRst   = 31'd9320676;
  localparam logic [StepWidth-1:0]       StepImagRst   = 31'd17895697;
  localparam logic [IterWidth-1:0]       IterLimitRst  = 16'd255;

  // Default parameter values
  localparam int unsigned ColumnCountDef = 1024;
  localparam int unsigned RowCountDef    = 1024;
  localparam int unsigned FracBitsDef    = 28;

  // Controller -> datapath commands
  typedef struct packed {
    logic load_pix;  // latch clamped pixel indices
    logic init_c;    // form c, clear z and count
    logic mul;       // register the three squared/cross products
    logic upd;       // z <= z^2 + c, count + 1
    logic out_load;  // load the result register
  } mbe_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic escaped;   // |z|^2 >= 4 for the current z
    logic at_limit;  // count equals the iteration limit
  } mbe_status_t;

endpackage

// ===== rtl/core/mbe_if.sv =====
// ----------------------------------------------------------------------------
// mbe_if
// Valid/ready channels for pixel requests and escape-time results.
// ----------------------------------------------------------------------------
interface mbe_pix_if;
  logic                               valid;
  logic                               ready;
  logic [mbe_pkg::IndexWidth-1:0]     column;
  logic [mbe_pkg::IndexWidth-1:0]     row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

interface mbe_res_if;
  logic                               valid;
  logic                               ready;
  logic                               inside_res;
  logic [mbe_pkg::IterWidth-1:0]      iterations;

  modport source (output valid, output inside_res, output iterations, input ready);
  modport sink   (input valid, input inside_res, input iterations, output ready);
endinterface

// ===== rtl/core/mandelbrot_escape_test_top.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_test_top
// Mandelbrot escape-time engine: one pixel in, one bounded/iteration-count
// result out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                  payload
//  pix_i    in   pix_i.valid/pix_i.ready    column[9:0], row[9:0]
//  res_o    out  res_o.valid/res_o.ready    inside_res, iterations[15:0]
//  cfg      in   cfg_we_i (no wait)         cfg_idx_i[2:0], cfg_wdata_i[31:0]
//
//  After accept, a pixel runs through the c setup, then a multiply step and an
//  update step per iteration through the three 32x32 multipliers, plus the
//  final test.
//  One pixel is in work at a time; a new pixel is taken while a result waits.
//  A stalled result holds the engine in its final test until the slot frees.
//  Reset restores the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module mandelbrot_escape_test_top #(
  parameter int unsigned COLUMN_COUNT = mbe_pkg::ColumnCountDef,
  parameter int unsigned ROW_COUNT    = mbe_pkg::RowCountDef,
  parameter int unsigned FRAC_BITS    = mbe_pkg::FracBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mbe_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [mbe_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  mbe_pix_if.sink                          pix_i,
  mbe_res_if.source                        res_o
);

  mbe_pkg::mbe_cmd_t    cmd;
  mbe_pkg::mbe_status_t status;

  mbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_i.valid),
    .pix_ready_o (pix_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mbe_dp #(
    .COLUMN_COUNT (COLUMN_COUNT),
    .ROW_COUNT    (ROW_COUNT),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .column_i     (pix_i.column),
    .row_i        (pix_i.row),
    .cmd_i        (cmd),
    .status_o     (status),
    .inside_res_o (res_o.inside_res),
    .iterations_o (res_o.iterations)
  );

`ifndef SYNTHESIS
  // A result is only loaded when the output slot is free
  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!res_o.valid || res_o.ready))
    else $error("result loaded over a pending transaction");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> res_o.valid)
    else $error("loaded result not presented");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_pix, cmd.init_c, cmd.mul, cmd.upd, cmd.out_load}))
    else $error("conflicting datapath commands");

  // After a pixel is taken the engine is busy for at least the c setup
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> !pix_i.ready)
    else $error("pixel accepted while busy");
`endif

endmodule

// ===== rtl/core/mbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer: pixel intake, c setup, multiply/update loop, result handoff.
// ----------------------------------------------------------------------------
module mbe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pix_valid_i,
  output logic                 pix_ready_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  input  mbe_pkg::mbe_status_t status_i,
  output mbe_pkg::mbe_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StCinit = 4'b0010,
    StMul   = 4'b0100,
    StUpd   = 4'b1000
  } mbe_state_e;

  mbe_state_e state_q, state_d;
  logic       res_valid_q, res_valid_d;
  logic       slot_free;
  logic       finish;

  assign slot_free = !res_valid_q || res_ready_i;
  assign finish    = status_i.escaped || status_i.at_limit;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (pix_valid_i) begin
          cmd_o.load_pix = 1'b1;
          state_d        = StCinit;
        end
      end
      StCinit: begin
        cmd_o.init_c = 1'b1;
        state_d      = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StUpd;
      end
      StUpd: begin
        if (finish) begin
          // hold here until the result register can take the transaction
          if (slot_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = StIdle;
          end
        end else begin
          cmd_o.upd = 1'b1;
          state_d   = StMul;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_valid_q && res_ready_i) res_valid_d = 1'b0;
    if (cmd_o.out_load)             res_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign pix_ready_o = (state_q == StIdle);
  assign res_valid_o = res_valid_q;

endmodule

// ===== rtl/core/mbe_dp.sv =====
// ----------------------------------------------------------------------------
// mbe_dp
// Datapath: configuration registers, c generation, complex square-and-add
// with saturation, escape compare, iteration count and result register.
// ----------------------------------------------------------------------------
module mbe_dp #(
  parameter int unsigned COLUMN_COUNT = mbe_pkg::ColumnCountDef,
  parameter int unsigned ROW_COUNT    = mbe_pkg::RowCountDef,
  parameter int unsigned FRAC_BITS    = mbe_pkg::FracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mbe_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [mbe_pkg::CfgDataWidth-1:0]    cfg_wdata_i,
  input  logic [mbe_pkg::IndexWidth-1:0]      column_i,
  input  logic [mbe_pkg::IndexWidth-1:0]      row_i,
  input  mbe_pkg::mbe_cmd_t                   cmd_i,
  output mbe_pkg::mbe_status_t                status_o,
  output logic                                inside_res_o,
  output logic [mbe_pkg::IterWidth-1:0]       iterations_o
);

  localparam int unsigned ColMax = COLUMN_COUNT - 1;
  localparam int unsigned RowMax = ROW_COUNT - 1;
  localparam logic signed [65:0] Four = 66'sd4 <<< FRAC_BITS;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647)       r = 32'sh7fff_ffff;
    else if (v < -66'sd2147483648) r = 32'sh8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

  // Configuration
  logic signed [31:0]                 origin_real_q, origin_imag_q;
  logic [mbe_pkg::StepWidth-1:0]      step_real_q, step_imag_q;
  logic [mbe_pkg::IterWidth-1:0]      limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_real_q <= mbe_pkg::OriginRealRst;
      origin_imag_q <= mbe_pkg::OriginImagRst;
      step_real_q   <= mbe_pkg::StepRealRst;
      step_imag_q   <= mbe_pkg::StepImagRst;
      limit_q       <= mbe_pkg::IterLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mbe_pkg::CfgOriginReal: origin_real_q <= cfg_wdata_i;
        mbe_pkg::CfgOriginImag: origin_imag_q <= cfg_wdata_i;
        mbe_pkg::CfgStepReal:   step_real_q   <= cfg_wdata_i[mbe_pkg::StepWidth-1:0];
        mbe_pkg::CfgStepImag:   step_imag_q   <= cfg_wdata_i[mbe_pkg::StepWidth-1:0];
        mbe_pkg::CfgIterLimit:  limit_q       <= cfg_wdata_i[mbe_pkg::IterWidth-1:0];
        default: ;
      endcase
    end
  end

  // Pixel latch with clamp to the last valid index
  logic [mbe_pkg::IndexWidth-1:0] col_q, row_q, col_d, row_d;

  always_comb begin
    col_d = column_i;
    row_d = row_i;
    if (32'(column_i) > 32'(ColMax)) col_d = mbe_pkg::IndexWidth'(ColMax);
    if (32'(row_i) > 32'(RowMax))    row_d = mbe_pkg::IndexWidth'(RowMax);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pix) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // c = origin + index * step
  logic signed [42:0] prod_cr, prod_ci;
  logic signed [31:0] cr_q, ci_q;

  assign prod_cr = $signed({1'b0, col_q}) * $signed({1'b0, step_real_q});
  assign prod_ci = $signed({1'b0, row_q}) * $signed({1'b0, step_imag_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_c) begin
      cr_q <= sat32(66'(origin_real_q) + 66'(prod_cr));
      ci_q <= sat32(66'(origin_imag_q) + 66'(prod_ci));
    end
  end

  // Products, floored to the fixed-point grid
  logic signed [31:0] zr_q, zi_q;
  logic signed [63:0] prod_rr, prod_ii, prod_ri;
  logic signed [63:0] rr_q, ii_q, ri_q;

  assign prod_rr = zr_q * zr_q;
  assign prod_ii = zi_q * zi_q;
  assign prod_ri = zr_q * zi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      rr_q <= prod_rr >>> FRAC_BITS;
      ii_q <= prod_ii >>> FRAC_BITS;
      ri_q <= prod_ri >>> FRAC_BITS;
    end
  end

  // Update and iteration count
  logic signed [65:0]            mag;
  logic [mbe_pkg::IterWidth-1:0] n_q;

  assign mag = 66'(rr_q) + 66'(ii_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_c) begin
      zr_q <= '0;
      zi_q <= '0;
    end else if (cmd_i.upd) begin
      zr_q <= sat32(66'(rr_q) - 66'(ii_q) + 66'(cr_q));
      zi_q <= sat32((66'(ri_q) <<< 1) + 66'(ci_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (cmd_i.init_c) begin
      n_q <= '0;
    end else if (cmd_i.upd) begin
      n_q <= n_q + 1'b1;
    end
  end

  // Before the first update z is zero, so the compare never fires there
  assign status_o.escaped  = (mag >= Four);
  assign status_o.at_limit = (n_q == limit_q);

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      inside_res_o <= !status_o.escaped;
      iterations_o <= n_q;
    end
  end

endmodule
